[rtl/xpr_pkg.sv]
// Package for the packet receiver: sizes, result kinds, controller states
// and the command and status bundles between controller and datapath.
// No dependencies.
package xpr_pkg;

   localparam int PAYLOAD_BYTES = 128;
   localparam int WORD_COUNT    = (PAYLOAD_BYTES + 7) / 8;
   localparam int CNT_W         = $clog2(PAYLOAD_BYTES);
   localparam int ADDR_W        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BYTE_W        = 8;
   localparam int WORD_W        = 64;
   localparam int KIND_W        = 2;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [BYTE_W-1:0]      START_CODE_RESET = 8'd1;
   localparam logic [BYTE_W-1:0]      END_CODE_RESET   = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_CODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_CODE     = 2'd1;

   typedef enum logic [KIND_W-1:0] {
      KIND_WORD = 2'd0,
      KIND_ACK  = 2'd1,
      KIND_NAK  = 2'd2,
      KIND_GO   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_NUMBER,
      ST_PAYLOAD,
      ST_CHECK,
      ST_RD_ISSUE,
      ST_RD_SEND,
      ST_ACK
   } state_type;

   typedef struct packed {
      logic     take_number;
      logic     clear_sum;
      logic     take_payload;
      logic     clear_idx;
      logic     next_idx;
      logic     load_out;
      kind_type out_kind;
   } cmd_type;

   typedef struct packed {
      logic is_start;
      logic is_end;
      logic cpl_match;
      logic payload_done;
      logic sum_match;
      logic idx_last;
      logic out_free;
   } sts_type;

endpackage

[rtl/xpr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module xpr_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/xpr_ctrl.sv]
// Controller of the packet receiver: packet phases and word read-out sequencing.
// Depends on xpr_pkg.
module xpr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  xpr_pkg::sts_type sts,
   output xpr_pkg::cmd_type cmd,
   output xpr_pkg::state_type state
);
   import xpr_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = sts.out_free;
            accept    = req_valid && req_ready;
            if (accept) begin
               if (sts.is_start) begin
                  state_in = ST_START;
               end
               if (sts.is_end) begin
                  cmd.load_out = 1'b1;
                  cmd.out_kind = KIND_GO;
               end
            end
         end
         ST_START: begin
            req_ready = sts.out_free;
            accept    = req_valid && req_ready;
            if (accept) begin
               cmd.take_number = 1'b1;
               state_in        = ST_NUMBER;
            end
         end
         ST_NUMBER: begin
            req_ready = sts.out_free;
            accept    = req_valid && req_ready;
            if (accept && sts.cpl_match) begin
               cmd.clear_sum = 1'b1;
               state_in      = ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            req_ready = sts.out_free;
            accept    = req_valid && req_ready;
            if (accept) begin
               cmd.take_payload = 1'b1;
               if (sts.payload_done) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            req_ready = sts.out_free;
            accept    = req_valid && req_ready;
            if (accept) begin
               if (sts.sum_match) begin
                  cmd.clear_idx = 1'b1;
                  state_in      = ST_RD_ISSUE;
               end else begin
                  cmd.load_out = 1'b1;
                  cmd.out_kind = KIND_NAK;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_RD_ISSUE: begin
            state_in = ST_RD_SEND;
         end
         ST_RD_SEND: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_kind = KIND_WORD;
               if (sts.idx_last) begin
                  state_in = ST_ACK;
               end else begin
                  cmd.next_idx = 1'b1;
                  state_in     = ST_RD_ISSUE;
               end
            end
         end
         ST_ACK: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_kind = KIND_ACK;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign state = state_ff;

endmodule

[rtl/xpr_datapath.sv]
// Datapath of the packet receiver: code registers, packet number, byte count,
// running sum, word assembly into the payload RAM and the result register.
// Depends on xpr_pkg and xpr_ram.
module xpr_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wen,
   input  logic [xpr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [xpr_pkg::BYTE_W-1:0]         csr_wdata,
   input  logic [xpr_pkg::BYTE_W-1:0]         req_rx_byte,
   input  xpr_pkg::cmd_type                   cmd,
   output xpr_pkg::sts_type                   sts,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [xpr_pkg::KIND_W-1:0]         rsp_kind,
   output logic [xpr_pkg::WORD_W-1:0]         rsp_word,
   output logic                               rsp_last
);
   import xpr_pkg::*;

   logic [BYTE_W-1:0] start_code_ff;
   logic [BYTE_W-1:0] end_code_ff;
   logic [BYTE_W-1:0] packet_number_ff;
   logic [BYTE_W-1:0] packet_number_in;
   logic [CNT_W-1:0]  byte_count_ff;
   logic [CNT_W-1:0]  byte_count_in;
   logic [BYTE_W-1:0] running_sum_ff;
   logic [BYTE_W-1:0] running_sum_in;
   logic [WORD_W-1:0] acc_ff;
   logic [WORD_W-1:0] acc_in;
   logic [ADDR_W-1:0] word_idx_ff;
   logic [ADDR_W-1:0] word_idx_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   kind_type          rsp_kind_ff;
   kind_type          rsp_kind_in;
   logic [WORD_W-1:0] rsp_word_ff;
   logic [WORD_W-1:0] rsp_word_in;
   logic              rsp_last_ff;
   logic              rsp_last_in;

   logic [2:0]        lane;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff <= START_CODE_RESET;
         end_code_ff   <= END_CODE_RESET;
      end else if (csr_wen) begin
         if (csr_index == CSR_START_CODE) begin
            start_code_ff <= csr_wdata;
         end
         if (csr_index == CSR_END_CODE) begin
            end_code_ff <= csr_wdata;
         end
      end
   end

   assign lane        = byte_count_ff[2:0];
   assign ram_wr_addr = ADDR_W'(byte_count_ff >> 3);

   always_comb begin
      sts.is_start     = (req_rx_byte == start_code_ff);
      sts.is_end       = (req_rx_byte == end_code_ff);
      sts.cpl_match    = (~packet_number_ff == req_rx_byte);
      sts.payload_done = (byte_count_ff == CNT_W'(PAYLOAD_BYTES - 1));
      sts.sum_match    = (running_sum_ff == req_rx_byte);
      sts.idx_last     = (word_idx_ff == ADDR_W'(WORD_COUNT - 1));
      sts.out_free     = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      packet_number_in = packet_number_ff;
      byte_count_in    = byte_count_ff;
      running_sum_in   = running_sum_ff;
      acc_in           = acc_ff;
      word_idx_in      = word_idx_ff;
      ram_wr_en        = 1'b0;

      if (cmd.take_number) begin
         packet_number_in = req_rx_byte;
      end
      if (cmd.clear_sum) begin
         byte_count_in  = '0;
         running_sum_in = '0;
      end
      if (cmd.take_payload) begin
         if (lane == 3'd0) begin
            acc_in = WORD_W'(req_rx_byte);
         end else begin
            acc_in = acc_ff | (WORD_W'(req_rx_byte) << {lane, 3'b000});
         end
         ram_wr_en      = (lane == 3'd7) || sts.payload_done;
         byte_count_in  = byte_count_ff + CNT_W'(1);
         running_sum_in = running_sum_ff + req_rx_byte;
      end
      if (cmd.clear_idx) begin
         word_idx_in = '0;
      end else if (cmd.next_idx) begin
         word_idx_in = word_idx_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = cmd.out_kind;
         rsp_word_in  = (cmd.out_kind == KIND_WORD) ? ram_rd_data : '0;
         rsp_last_in  = (cmd.out_kind != KIND_WORD);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_number_ff <= '0;
         byte_count_ff    <= '0;
         running_sum_ff   <= '0;
         word_idx_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         packet_number_ff <= packet_number_in;
         byte_count_ff    <= byte_count_in;
         running_sum_ff   <= running_sum_in;
         word_idx_ff      <= word_idx_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   xpr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORD_COUNT)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (acc_in),
      .rd_addr (word_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_word  = rsp_word_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

[rtl/xmodem_packet_receiver.sv]
// XMODEM checksum receiver, one received byte per req beat.
// Input channel req_valid/req_ready carries req_rx_byte from the serial link.
// Result channel rsp_valid/rsp_ready carries rsp_kind (0 payload word, 1 ack,
// 2 nak, 3 ack and start application), rsp_word (eight payload bytes, first
// byte least significant, zero for other kinds) and rsp_last (set on the final
// result that a byte causes).
// csr_wen/csr_index/csr_wdata write the start code (index 0) and end code
// (index 1); writes take effect at once and have no wait.
// Throughput: one byte per cycle outside the payload read-out while the result
// register is free. A result sits in a single output register; a new byte is
// taken while it waits only if it is taken in the same cycle (rsp_ready high).
// A good checksum byte starts the payload read-out, ST_RD_ISSUE then ST_RD_SEND
// per word on the registered read port of the payload RAM and ST_ACK last,
// before the next byte is taken; rsp_ready low holds the read-out in place.
// Nak and start-application results appear in the cycle after their byte.
// Reset (synchronous, active high) returns to idle, sets the codes to 1 and 4
// and drops any pending result. The payload RAM needs no clearing.
// Depends on xpr_pkg, xpr_ctrl, xpr_datapath and xpr_ram.
module xmodem_packet_receiver (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [xpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [xpr_pkg::BYTE_W-1:0]      csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [xpr_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [xpr_pkg::KIND_W-1:0]      rsp_kind,
   output logic [xpr_pkg::WORD_W-1:0]      rsp_word,
   output logic                            rsp_last
);
   import xpr_pkg::*;

   cmd_type   cmd;
   sts_type   sts;
   state_type state;

   xpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd),
      .state     (state)
   );

   xpr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_rx_byte (req_rx_byte),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_kind    (rsp_kind),
      .rsp_word    (rsp_word),
      .rsp_last    (rsp_last)
   );

   a_ready_needs_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("byte taken while the result register is blocked");

   a_last_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != KIND_WORD)))
      else $error("last flag does not match result kind");

   a_no_word_on_control: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_WORD) |-> (rsp_word == '0))
      else $error("nonzero word on a control result");

   a_readout_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state == ST_RD_ISSUE || state == ST_RD_SEND || state == ST_ACK) |-> !req_ready)
      else $error("byte taken during payload read-out");

endmodule

[dv/xmodem_packet_receiver_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for xmodem_packet_receiver: a directed table, then a random
// packet, a stalled burst of end codes and line noise, checked beat by beat.
// Depends on xpr_pkg and the receiver RTL.
module xmodem_packet_receiver_tb;
   import xpr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 2 * WORD_COUNT + 4;
   localparam int HOLD_AT     = 2 * PAYLOAD_BYTES + 22;
   localparam int HOLD_CYCLES = 300;
   localparam int BURST_ITEMS = 12;
   localparam int NOISE_ITEMS = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      kind_type          kind;
      logic [WORD_W-1:0] word;
      logic              last;
   } rx_result_type;

   typedef enum logic [1:0] {ROW_BYTE, ROW_FILL, ROW_CSR} row_op_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GO, CHK_NAK} row_chk_type;

   typedef struct packed {
      row_op_type             op;
      logic [CSR_INDEX_W-1:0] idx;
      logic [BYTE_W-1:0]      val;
      row_chk_type            chk;
   } row_type;

   localparam int PLAN_LEN = 22;

   row_type plan [PLAN_LEN] = '{
      '{ROW_BYTE, CSR_START_CODE, 8'h00, CHK_NONE},
      '{ROW_BYTE, CSR_START_CODE, 8'hFF, CHK_NONE},
      '{ROW_BYTE, CSR_START_CODE, 8'h04, CHK_GO},
      '{ROW_BYTE, CSR_START_CODE, 8'h01, CHK_NONE},
      '{ROW_BYTE, CSR_START_CODE, 8'h04, CHK_NONE},
      '{ROW_BYTE, CSR_START_CODE, 8'h04, CHK_NONE},
      '{ROW_BYTE, CSR_START_CODE, 8'h00, CHK_NONE},
      '{ROW_BYTE, CSR_START_CODE, 8'hFB, CHK_NONE},
      '{ROW_FILL, CSR_START_CODE, 8'hFF, CHK_MODEL},
      '{ROW_BYTE, CSR_START_CODE, 8'h81, CHK_NAK},
      '{ROW_CSR,  CSR_START_CODE, 8'h00, CHK_NONE},
      '{ROW_CSR,  CSR_END_CODE,   8'hFF, CHK_NONE},
      '{ROW_BYTE, CSR_START_CODE, 8'hFF, CHK_GO},
      '{ROW_BYTE, CSR_START_CODE, 8'h01, CHK_NONE},
      '{ROW_BYTE, CSR_START_CODE, 8'h04, CHK_NONE},
      '{ROW_CSR,  CSR_START_CODE, 8'h5A, CHK_NONE},
      '{ROW_CSR,  CSR_END_CODE,   8'h5A, CHK_NONE},
      '{ROW_CSR,  CSR_SPARE_A,    8'h77, CHK_NONE},
      '{ROW_CSR,  CSR_SPARE_B,    8'h33, CHK_NONE},
      '{ROW_BYTE, CSR_START_CODE, 8'h77, CHK_NONE},
      '{ROW_BYTE, CSR_START_CODE, 8'h33, CHK_NONE},
      '{ROW_BYTE, CSR_START_CODE, 8'h5A, CHK_GO}
   };

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   csr_wen     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [BYTE_W-1:0]      csr_wdata   = '0;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   logic [KIND_W-1:0]      rsp_kind;
   logic [WORD_W-1:0]      rsp_word;
   logic                   rsp_last;

   xmodem_packet_receiver dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_kind    (rsp_kind),
      .rsp_word    (rsp_word),
      .rsp_last    (rsp_last)
   );

   state_type         rx_phase  = ST_IDLE;
   logic [BYTE_W-1:0] start_m   = START_CODE_RESET;
   logic [BYTE_W-1:0] end_m     = END_CODE_RESET;
   logic [BYTE_W-1:0] pkt_num   = '0;
   logic [BYTE_W-1:0] pay_sum   = '0;
   int                pay_cnt   = 0;
   logic [BYTE_W-1:0] pay_buf [PAYLOAD_BYTES];

   rx_result_type step_rsp [$];
   rx_result_type awaited_rsp [$];
   rx_result_type want;

   int  errors  = 0;
   int  taken   = 0;
   int  cycles  = 0;
   bit  calm    = 1'b0;
   bit  held    = 1'b0;

   function automatic void absorb_byte(input logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] acc;
      int                idx;
      step_rsp.delete();
      case (rx_phase)
         ST_START: begin
            pkt_num  = b;
            rx_phase = ST_NUMBER;
         end
         ST_NUMBER: begin
            if (~pkt_num == b) begin
               rx_phase = ST_PAYLOAD;
               pay_cnt  = 0;
               pay_sum  = '0;
            end
         end
         ST_PAYLOAD: begin
            pay_buf[pay_cnt] = b;
            pay_cnt++;
            pay_sum += b;
            if (pay_cnt >= PAYLOAD_BYTES) rx_phase = ST_CHECK;
         end
         ST_CHECK: begin
            if (pay_sum == b) begin
               for (int w = 0; w < WORD_COUNT; w++) begin
                  acc = '0;
                  for (int i = 0; i < 8; i++) begin
                     idx = w * 8 + i;
                     if (idx < PAYLOAD_BYTES) acc[i*8 +: 8] = pay_buf[idx];
                  end
                  step_rsp.push_back(rx_result_type'{kind: KIND_WORD, word: acc,
                                                     last: 1'b0});
               end
               step_rsp.push_back(rx_result_type'{kind: KIND_ACK, word: '0, last: 1'b1});
            end else begin
               step_rsp.push_back(rx_result_type'{kind: KIND_NAK, word: '0, last: 1'b1});
            end
            rx_phase = ST_IDLE;
         end
         default: begin
            rx_phase = ST_IDLE;
            if (b == start_m) rx_phase = ST_START;
            if (b == end_m) begin
               step_rsp.push_back(rx_result_type'{kind: KIND_GO, word: '0, last: 1'b1});
            end
         end
      endcase
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b, input row_chk_type chk);
      while (!calm && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      taken++;
      absorb_byte(b);
      case (chk)
         CHK_MODEL: foreach (step_rsp[i]) awaited_rsp.push_back(step_rsp[i]);
         CHK_GO: begin
            awaited_rsp.push_back(rx_result_type'{kind: KIND_GO, word: '0, last: 1'b1});
         end
         CHK_NAK: begin
            awaited_rsp.push_back(rx_result_type'{kind: KIND_NAK, word: '0, last: 1'b1});
         end
         default: ;
      endcase
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      settle();
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_START_CODE) start_m = val;
      else if (idx == CSR_END_CODE) end_m = val;
   endtask

   // complete whatever packet is open, with a good checksum
   task automatic finish_packet();
      while (rx_phase != ST_IDLE) begin
         case (rx_phase)
            ST_NUMBER: send_byte(~pkt_num, CHK_MODEL);
            ST_CHECK:  send_byte(pay_sum, CHK_MODEL);
            default:   send_byte(8'($urandom), CHK_MODEL);
         endcase
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!held && taken >= HOLD_AT) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 19);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            $error("unexpected result beat: kind %0d word %h last %0b",
                   rsp_kind, rsp_word, rsp_last);
            errors++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("rsp_kind: expected %0d, got %0d", want.kind, rsp_kind);
               errors++;
            end
            if (rsp_word !== want.word) begin
               $error("rsp_word: expected %h, got %h", want.word, rsp_word);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("rsp_last: expected %0b, got %0b", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   initial begin
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] new_start;
      logic [BYTE_W-1:0] new_end;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         case (plan[r].op)
            ROW_CSR: write_reg(plan[r].idx, plan[r].val);
            ROW_FILL: begin
               while (rx_phase != ST_CHECK) begin
                  if (rx_phase == ST_NUMBER) send_byte(~pkt_num, CHK_MODEL);
                  else send_byte(plan[r].val, CHK_MODEL);
               end
            end
            default: send_byte(plan[r].val, plan[r].chk);
         endcase
      end

      calm = 1'b1;
      finish_packet();
      calm = 1'b0;

      write_reg(CSR_START_CODE, 8'hFF);
      write_reg(CSR_END_CODE, 8'h00);
      for (int i = 0; i < BURST_ITEMS; i++) begin
         if ((i % 2) == 0) begin
            send_byte(end_m, CHK_MODEL);
         end else begin
            do b = 8'($urandom); while (b == start_m || b == end_m);
            send_byte(b, CHK_MODEL);
         end
      end

      do begin
         new_start = 8'($urandom);
         new_end   = 8'($urandom);
      end while (new_start == new_end);
      write_reg(CSR_START_CODE, new_start);
      write_reg(CSR_END_CODE, new_end);
      write_reg(CSR_SPARE_A, 8'($urandom));
      repeat (NOISE_ITEMS) begin
         if ($urandom_range(0, 99) < 40) begin
            send_byte(end_m, CHK_MODEL);
         end else begin
            do b = 8'($urandom); while (b == start_m);
            send_byte(b, CHK_MODEL);
         end
      end

      settle();
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
